// File: src/msix_vte_pkg.sv
// msix_vte_pkg: constants, codes and controller/datapath interface types
// for the msi-x vector table emulator; no dependencies
package msix_vte_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int WORDS = TABLE_ENTRIES * 4;
	localparam int WADDR_W = IDX_W + 2;

	localparam logic [1:0] ACT_READ = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_SWEEP = 2'd2;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_MASK = 2'd1;
	localparam logic [1:0] KIND_ROUTE = 2'd2;

	localparam logic [1:0] WORD_ADDR_LO = 2'd0;
	localparam logic [1:0] WORD_DATA = 2'd2;
	localparam logic [1:0] WORD_CTRL = 2'd3;

	typedef struct packed {
		logic load;
		logic rd_word;
		logic rd_route;
		logic wr_commit;
		logic idx_inc;
		logic emit_read;
		logic emit_route;
		logic emit_mask;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic fits;
		logic ctrl_word;
		logic route_req;
		logic idx_dirty;
		logic idx_last;
		logic out_free;
	} stat_t;

endpackage

// File: src/msix_vector_table_emulator.sv
// msix_vector_table_emulator: top level of the msi-x vector table emulator
// depends on msix_vte_pkg, msix_vte_ctrl and msix_vte_dp
//
// One input beat is handled at a time; in_stall stays high from acceptance
// until the beat's work is done. A read passes through the DECODE and EXEC
// states of the single sequencer, with a registered read of the table memory,
// and loads its result beat from EXEC. An address or data write commits in
// EXEC; a control-word write goes on to MASK, through ROUTE first when it
// also reports a route update. A sweep visits each entry in SWEEP, with a
// ROUTE step for each dirty entry. Any state that loads a result waits while
// out_stall holds the result register. A finished result waits in that
// register while the next beat is accepted. Table words and dirty marks are
// cleared by reset without a sweep of the memory. Write table_enabled only
// while no beat is in progress.
module msix_vector_table_emulator
	import msix_vte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  entry_index,
	output logic [31:0] read_data,
	output logic        mask_bit,
	output logic [7:0]  vector,
	output logic [15:0] route_flags,
	output logic        last
);

	cmd_t  cmd;
	stat_t stat;

	msix_vte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	msix_vte_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.action         (action),
		.byte_offset    (byte_offset),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.entry_index    (entry_index),
		.read_data      (read_data),
		.mask_bit       (mask_bit),
		.vector         (vector),
		.route_flags    (route_flags),
		.last           (last)
	);

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_read, cmd.emit_route, cmd.emit_mask}))
		else $error("more than one result loaded in a cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_read || cmd.emit_route || cmd.emit_mask) |-> stat.out_free)
		else $error("result loaded over a waiting beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not held off after accepting a beat");

	a_mask_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_MASK)) |-> last)
		else $error("mask write beat not marked last");

endmodule

// File: src/msix_vte_ctrl.sv
// msix_vte_ctrl: one-hot sequencer for reads, writes, mask updates and sweeps
// depends on msix_vte_pkg
module msix_vte_ctrl
	import msix_vte_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_SWEEP  = 6'b001000,
		ST_ROUTE  = 6'b010000,
		ST_MASK   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.action)
					ACT_READ: begin
						cmd.rd_word = 1'b1;
						state_next = ST_EXEC;
					end
					ACT_WRITE: begin
						if (stat.fits) begin
							cmd.rd_word = 1'b1;
							state_next = ST_EXEC;
						end else begin
							state_next = ST_IDLE;
						end
					end
					ACT_SWEEP: begin
						state_next = ST_SWEEP;
					end
					default: begin
						state_next = ST_IDLE;
					end
				endcase
			end
			ST_EXEC: begin
				if (stat.action == ACT_READ) begin
					if (stat.out_free) begin
						cmd.emit_read = 1'b1;
						state_next = ST_IDLE;
					end
				end else begin
					cmd.wr_commit = 1'b1;
					if (!stat.ctrl_word) begin
						state_next = ST_IDLE;
					end else if (stat.route_req) begin
						cmd.rd_route = 1'b1;
						state_next = ST_ROUTE;
					end else begin
						state_next = ST_MASK;
					end
				end
			end
			ST_SWEEP: begin
				if (stat.idx_dirty) begin
					cmd.rd_route = 1'b1;
					state_next = ST_ROUTE;
				end else if (stat.idx_last) begin
					state_next = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_ROUTE: begin
				if (stat.out_free) begin
					cmd.emit_route = 1'b1;
					if (stat.action == ACT_WRITE) begin
						state_next = ST_MASK;
					end else if (stat.idx_last) begin
						state_next = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_next = ST_SWEEP;
					end
				end
			end
			ST_MASK: begin
				if (stat.out_free) begin
					cmd.emit_mask = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/msix_vte_dp.sv
// msix_vte_dp: vector table memory, valid and dirty bits, enable register
// and result register; depends on msix_vte_pkg
module msix_vte_dp
	import msix_vte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  entry_index,
	output logic [31:0] read_data,
	output logic        mask_bit,
	output logic [7:0]  vector,
	output logic [15:0] route_flags,
	output logic        last
);

	logic                     table_en_q;
	logic [1:0]               action_q;
	logic [7:0]               offset_q;
	logic [31:0]              wdata_q;
	logic [IDX_W-1:0]         idx_q;
	logic [TABLE_ENTRIES-1:0] dirty_q;
	logic [WORDS-1:0]         word_vld_q;
	logic [31:0]              mem_q [WORDS];
	logic [31:0]              rd_a_q;
	logic [31:0]              rd_b_q;
	logic                     vld_a_q;
	logic                     vld_b_q;
	logic                     out_valid_q;

	logic [3:0]         ent;
	logic [1:0]         wsel;
	logic               fits;
	logic               locked;
	logic               we;
	logic [WADDR_W-1:0] ra;
	logic [WADDR_W-1:0] rb;
	logic [WADDR_W-1:0] wa;
	logic [31:0]        word_a;
	logic [31:0]        word_b;
	logic               above;
	logic               out_free;
	logic               emit;
	logic [15:0]        flags;

	assign ent = offset_q[7:4];
	assign wsel = offset_q[3:2];
	assign fits = (offset_q[1:0] == 2'd0) && (32'(ent) < TABLE_ENTRIES);
	assign word_a = vld_a_q ? rd_a_q : 32'd0;
	assign word_b = vld_b_q ? rd_b_q : 32'd0;
	assign locked = table_en_q && !word_b[0];
	assign ra = cmd.rd_route ? {idx_q, WORD_ADDR_LO} : {idx_q, wsel};
	assign rb = cmd.rd_route ? {idx_q, WORD_DATA} : {idx_q, WORD_CTRL};
	assign wa = {idx_q, wsel};
	assign we = cmd.wr_commit && ((wsel == WORD_CTRL) || !locked);
	assign flags = {word_b[15], word_b[10:8], 2'b00, word_a[2], word_a[3], word_a[19:12]};
	assign out_free = !out_valid_q || !out_stall;
	assign emit = cmd.emit_read || cmd.emit_route || cmd.emit_mask;

	always_comb begin
		above = 1'b0;
		for (int j = 0; j < TABLE_ENTRIES; j++) begin
			if (dirty_q[j] && (j > int'(idx_q))) begin
				above = 1'b1;
			end
		end
	end

	always_comb begin
		stat.action = action_q;
		stat.fits = fits;
		stat.ctrl_word = (wsel == WORD_CTRL);
		stat.route_req = table_en_q && !wdata_q[0] && dirty_q[idx_q];
		stat.idx_dirty = dirty_q[idx_q];
		stat.idx_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
		stat.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_en_q <= 1'b0;
			action_q <= ACT_READ;
			idx_q <= '0;
			dirty_q <= '0;
			word_vld_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				table_en_q <= cfg_write_data;
			end
			if (cmd.load) begin
				action_q <= action;
				idx_q <= (action == ACT_SWEEP) ? '0 : IDX_W'(byte_offset[7:4]);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.rd_word || cmd.rd_route) begin
				vld_a_q <= word_vld_q[ra];
				vld_b_q <= word_vld_q[rb];
			end
			if (we) begin
				word_vld_q[wa] <= 1'b1;
			end
			if (we && (wsel != WORD_CTRL) && (word_a != wdata_q)) begin
				dirty_q[idx_q] <= 1'b1;
			end else if (cmd.emit_route) begin
				dirty_q[idx_q] <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offset_q <= byte_offset;
			wdata_q <= write_data;
		end
		if (we) begin
			mem_q[wa] <= wdata_q;
		end
		if (cmd.rd_word || cmd.rd_route) begin
			rd_a_q <= mem_q[ra];
			rd_b_q <= mem_q[rb];
		end
		if (emit) begin
			kind <= KIND_READ;
			entry_index <= ent;
			read_data <= 32'd0;
			mask_bit <= 1'b0;
			vector <= 8'd0;
			route_flags <= 16'd0;
			last <= 1'b1;
			if (cmd.emit_read) begin
				read_data <= fits ? word_a : 32'd0;
			end else if (cmd.emit_route) begin
				kind <= KIND_ROUTE;
				entry_index <= 4'(idx_q);
				vector <= word_b[7:0];
				route_flags <= flags;
				last <= (action_q != ACT_WRITE) && !above;
			end else begin
				kind <= KIND_MASK;
				mask_bit <= wdata_q[0];
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
